/* rtl/core/sitab_pkg.sv */
// Shared constants, types and control structs for the symbol intern table.
`default_nettype none
package sitab_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int LANES         = 32;
    localparam int BANK_DEPTH    = TABLE_ENTRIES / LANES;
    localparam int LANE_W        = $clog2(LANES);
    localparam int STEP_W        = $clog2(BANK_DEPTH);
    localparam int INDEX_W       = $clog2(TABLE_ENTRIES);
    localparam int COUNT_W       = INDEX_W + 1;
    localparam int KEY_W         = 64;
    localparam int ID_W          = 16;
    localparam int CHAR_W        = 8;
    localparam int NUM_CHARS     = KEY_W / CHAR_W;

    localparam logic [CHAR_W-1:0] BLANK_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] BLANK_NUL   = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESOLVE
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [STEP_W-1:0] rd_addr;
        logic [STEP_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
    } lane_ctrl_t;

    typedef struct packed {
        logic              clear;
        logic              en;
        logic [STEP_W-1:0] step;
    } merge_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/sitab_lane.sv */
// One search lane: a bank of stored keys, registered read and key compare.
`default_nettype none
module sitab_lane
    import sitab_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lane_ctrl_t       ctrl,
    input  wire logic             wr_en,
    input  wire logic             in_use,
    input  wire logic [KEY_W-1:0] key,
    output logic                  hit
);

    logic [KEY_W-1:0] bank_reg [BANK_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;
    logic             valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank_reg[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= bank_reg[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl.rd_en & in_use;
        end
    end

    assign hit = valid_reg && (rd_data_reg == key);

endmodule
`default_nettype wire

/* rtl/core/sitab_merge.sv */
// Merges the lane hits of each scan step into a found flag and entry index.
`default_nettype none
module sitab_merge
    import sitab_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire merge_ctrl_t        ctrl,
    input  wire logic [LANES-1:0]   hits,
    output logic                    found,
    output logic [INDEX_W-1:0]      index
);

    logic               found_reg;
    logic               found_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic [LANE_W-1:0]  lane_sel;

    always_comb
    begin
        lane_sel = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                lane_sel = LANE_W'(i);
            end
        end
    end

    always_comb
    begin
        found_next = found_reg;
        index_next = index_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.en && (|hits))
        begin
            found_next = 1'b1;
            index_next = {ctrl.step, lane_sel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
    end

    assign found = found_reg;
    assign index = index_reg;

endmodule
`default_nettype wire

/* rtl/core/symbol_intern_table.sv */
// Symbol intern table: 32 search lanes over a 256-entry key store with insert on miss.
// Each item passes through accept, 8 scan steps, a drain and a resolve; resolve waits for a free output register.
// A new item is accepted only once the previous one has left resolve; the scan walks each 8-deep lane bank.
// A finished result waits in the output register while the next item is scanned.
// Reset clears the fill count, first_id and handshake state; store contents are not cleared.
`default_nettype none
module symbol_intern_table
    import sitab_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wen,
    input  wire logic [ID_W-1:0]   cfg_wdata,   // first_id
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [KEY_W-1:0]  s_tdata,     // symbol_chars
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [ID_W-1:0]        m_tdata,     // sym_id
    output logic [1:0]             m_tuser      // table_full, was_new
);

    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [STEP_W-1:0]  pipe_step_reg;
    logic               pipe_valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [ID_W-1:0]    first_id_reg;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [ID_W-1:0]    id_reg;
    logic               new_reg;
    logic               full_reg;
    logic [ID_W-1:0]    id_next;
    logic               new_next;
    logic               full_next;

    logic [KEY_W-1:0]   canon;
    logic               trimming;
    logic               accept;
    logic               out_free;
    logic               rd_en;
    logic               load_out;
    logic               do_write;
    logic               has_room;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic [LANES-1:0]   hits;
    logic [LANES-1:0]   in_use;
    logic [LANES-1:0]   wr_en;
    lane_ctrl_t         lane_ctrl;
    merge_ctrl_t        merge_ctrl;

    // trailing blanks sit in the low bytes
    always_comb
    begin
        canon    = s_tdata;
        trimming = 1'b1;
        for (int b = 0; b < NUM_CHARS; b++)
        begin
            if (trimming && ((canon[b*CHAR_W +: CHAR_W] == BLANK_SPACE) ||
                             (canon[b*CHAR_W +: CHAR_W] == BLANK_NUL)))
            begin
                canon[b*CHAR_W +: CHAR_W] = '0;
            end
            else
            begin
                trimming = 1'b0;
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign has_room = (count_reg < COUNT_W'(TABLE_ENTRIES));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == STEP_W'(BANK_DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_SCAN:    rd_en    = 1'b1;
            ST_DRAIN:   ;
            ST_RESOLVE: load_out = out_free;
            default:    ;
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign do_write = load_out && !found && has_room;

    always_comb
    begin
        step_next = step_reg;
        if (accept)
        begin
            step_next = '0;
        end
        else if (rd_en)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    assign count_next = do_write ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        if (found)
        begin
            id_next   = first_id_reg + ID_W'(found_index);
            new_next  = 1'b0;
            full_next = 1'b0;
        end
        else if (has_room)
        begin
            id_next   = first_id_reg + ID_W'(count_reg[INDEX_W-1:0]);
            new_next  = 1'b1;
            full_next = 1'b0;
        end
        else
        begin
            id_next   = '0;
            new_next  = 1'b0;
            full_next = 1'b1;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            pipe_valid_reg <= 1'b0;
            count_reg      <= '0;
            first_id_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pipe_valid_reg <= rd_en;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wen)
            begin
                first_id_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_step_reg <= step_reg;
        if (accept)
        begin
            key_reg <= canon;
        end
        if (load_out)
        begin
            id_reg   <= id_next;
            new_reg  <= new_next;
            full_reg <= full_next;
        end
    end

    assign lane_ctrl.rd_en   = rd_en;
    assign lane_ctrl.rd_addr = step_reg;
    assign lane_ctrl.wr_addr = count_reg[INDEX_W-1:LANE_W];
    assign lane_ctrl.wr_data = key_reg;

    assign merge_ctrl.clear = accept;
    assign merge_ctrl.en    = pipe_valid_reg;
    assign merge_ctrl.step  = pipe_step_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        assign in_use[l] = ({1'b0, step_reg, LANE_W'(l)} < count_reg);
        assign wr_en[l]  = do_write && (count_reg[LANE_W-1:0] == LANE_W'(l));

        sitab_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .wr_en  (wr_en[l]),
            .in_use (in_use[l]),
            .key    (key_reg),
            .hit    (hits[l])
        );
    end

    sitab_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (merge_ctrl),
        .hits  (hits),
        .found (found),
        .index (found_index)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = id_reg;
    assign m_tuser  = {full_reg, new_reg};

endmodule
`default_nettype wire
